>>> src/mjwm_pkg.sv
// Shared constants, types and helper functions for the mecanum wheel mixer.
package mjwm_pkg;

   // Datapath widths
   localparam int WHEELS     = 4;
   localparam int AXIS_W     = 8;
   localparam int FS_W       = 8;
   localparam int DZ_W       = 7;
   localparam int SUM_W      = 11;  // wheel sum, -511..512
   localparam int WMAG_W     = 10;  // wheel magnitude, 0..512
   localparam int DIV_W      = 10;  // divisor, 1..512
   localparam int NUM_W      = 16;  // magnitude * 100, up to 51200
   localparam int QUOT_W     = 7;   // duty percent, 0..100
   localparam int PERCENT    = 100;
   localparam int DIV_STAGES = 4;
   localparam int STEP_BITS  = 2;   // quotient bits resolved per divider stage

   // Register port
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_FULL_SCALE = 2'd0,
      REG_DEAD_ZONE  = 2'd1,
      REG_FULL_TURN  = 2'd2
   } reg_idx_type;

   localparam logic [FS_W-1:0] RST_FULL_SCALE = 8'd128;
   localparam logic [DZ_W-1:0] RST_DEAD_ZONE  = 7'd5;
   localparam logic            RST_FULL_TURN  = 1'b1;

   // Wheel order in all per-wheel vectors
   localparam int WHL_FL = 0;
   localparam int WHL_FR = 1;
   localparam int WHL_BL = 2;
   localparam int WHL_BR = 3;

   typedef struct packed {
      logic [FS_W-1:0] full_scale;
      logic [DZ_W-1:0] dead_zone;
      logic            full_turn;
   } cfg_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] left_x;
      logic signed [AXIS_W-1:0] left_y;
      logic signed [AXIS_W-1:0] right_x;
      logic signed [AXIS_W-1:0] right_y;
   } axes_type;

   typedef logic [WHEELS-1:0][SUM_W-1:0] sum_vec_type;

   typedef struct packed {
      logic [DIV_W-1:0]             divisor;
      logic [WHEELS-1:0][NUM_W-1:0] num;
      logic [WHEELS-1:0]            neg;
   } norm_type;

   typedef struct packed {
      logic [WHEELS-1:0][QUOT_W-1:0] quot;
      logic [WHEELS-1:0]             neg;
   } quot_type;

   // |axis|; -128 maps to 128, which still fits 8 unsigned bits
   function automatic logic [AXIS_W-1:0] axis_mag(input logic [AXIS_W-1:0] a);
      logic [AXIS_W-1:0] res;
      res = a[AXIS_W-1] ? (~a + 1'b1) : a;
      return res;
   endfunction

   // |wheel sum|
   function automatic logic [WMAG_W-1:0] sum_mag(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] abs_s;
      abs_s = s[SUM_W-1] ? (~s + 1'b1) : s;
      return abs_s[WMAG_W-1:0];
   endfunction

   // magnitude scaled to percent units (constant multiply, shift-add)
   function automatic logic [NUM_W-1:0] to_percent(input logic [WMAG_W-1:0] m);
      logic [NUM_W-1:0] res;
      res = NUM_W'(m) * NUM_W'(PERCENT);
      return res;
   endfunction

endpackage

>>> src/mjwm_chan_if.sv
// Valid/ready channel interfaces for joystick samples and wheel duty results.
interface mjwm_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] left_x;
   logic signed [7:0] left_y;
   logic signed [7:0] right_x;
   logic signed [7:0] right_y;
   logic              moved;

   modport source (output valid, left_x, left_y, right_x, right_y, moved, input ready);
   modport sink   (input valid, left_x, left_y, right_x, right_y, moved, output ready);
endinterface

interface mjwm_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] front_left_fwd;
   logic [6:0] front_left_rev;
   logic [6:0] front_right_fwd;
   logic [6:0] front_right_rev;
   logic [6:0] back_left_fwd;
   logic [6:0] back_left_rev;
   logic [6:0] back_right_fwd;
   logic [6:0] back_right_rev;

   modport source (output valid, front_left_fwd, front_left_rev, front_right_fwd,
                   front_right_rev, back_left_fwd, back_left_rev, back_right_fwd,
                   back_right_rev, input ready);
   modport sink   (input valid, front_left_fwd, front_left_rev, front_right_fwd,
                   front_right_rev, back_left_fwd, back_left_rev, back_right_fwd,
                   back_right_rev, output ready);
endinterface

>>> src/mjwm_mix.sv
// Pipeline stage 1: dead zone, forward fallback and mecanum mixing into four wheel sums.
module mjwm_mix import mjwm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  axes_type    in_axes,
   input  cfg_type     cfg,
   output logic        out_valid,
   input  logic        out_ready,
   output sum_vec_type out_sums
);

   logic        valid_ff, valid_in;
   sum_vec_type sums_ff, sums_in;

   logic                    x_on, y_on, r_on;
   logic signed [SUM_W-1:0] y_term, x_term, r_term, kr_term;

   // dead zone per axis; right_y is the forward fallback and has none
   always_comb begin
      y_on = axis_mag(in_axes.left_y)  > {1'b0, cfg.dead_zone};
      x_on = axis_mag(in_axes.left_x)  > {1'b0, cfg.dead_zone};
      r_on = axis_mag(in_axes.right_x) > {1'b0, cfg.dead_zone};

      y_term = y_on ? -SUM_W'(in_axes.left_y) : -SUM_W'(in_axes.right_y);
      x_term = x_on ? SUM_W'(in_axes.left_x) : '0;
      r_term = r_on ? SUM_W'(in_axes.right_x) : '0;
      kr_term = cfg.full_turn ? (r_term <<< 1) : r_term;

      sums_in[WHL_FL] = y_term + x_term + kr_term;
      sums_in[WHL_FR] = y_term - x_term - kr_term;
      sums_in[WHL_BL] = y_term - x_term + kr_term;
      sums_in[WHL_BR] = y_term + x_term - kr_term;
   end

   assign valid_in = in_valid;
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && valid_in) begin
         sums_ff <= sums_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sums  = sums_ff;

endmodule

>>> src/mjwm_norm.sv
// Pipeline stage 2: wheel magnitudes, largest magnitude, divisor choice and percent scaling.
module mjwm_norm import mjwm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  sum_vec_type in_sums,
   input  cfg_type     cfg,
   output logic        out_valid,
   input  logic        out_ready,
   output norm_type    out_norm
);

   logic     valid_ff;
   norm_type norm_ff, norm_in;

   logic [WHEELS-1:0][WMAG_W-1:0] mags;
   logic [WMAG_W-1:0]             max_01, max_23, max_all, fs_eff;

   // max over four wheels as a two-level compare tree
   always_comb begin
      for (int w = 0; w < WHEELS; w++) begin
         mags[w]        = sum_mag(in_sums[w]);
         norm_in.num[w] = to_percent(mags[w]);
         norm_in.neg[w] = in_sums[w][SUM_W-1];
      end
      max_01  = (mags[WHL_FL] > mags[WHL_FR]) ? mags[WHL_FL] : mags[WHL_FR];
      max_23  = (mags[WHL_BL] > mags[WHL_BR]) ? mags[WHL_BL] : mags[WHL_BR];
      max_all = (max_01 > max_23) ? max_01 : max_23;

      // zero full scale counts as one
      fs_eff = (cfg.full_scale == '0) ? WMAG_W'(1) : WMAG_W'(cfg.full_scale);
      norm_in.divisor = (max_all > fs_eff) ? DIV_W'(max_all) : DIV_W'(fs_eff);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         norm_ff <= norm_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_norm  = norm_ff;

endmodule

>>> src/mjwm_div.sv
// Pipelined restoring divider: four lanes, two quotient bits resolved per stage.
module mjwm_div import mjwm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  norm_type in_norm,
   output logic     out_valid,
   input  logic     out_ready,
   output quot_type out_quot
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES:0]   ready;

   logic [DIV_W-1:0]              div_ff    [DIV_STAGES];
   logic [WHEELS-1:0][NUM_W-1:0]  rem_ff    [DIV_STAGES];
   logic [WHEELS-1:0][NUM_W-1:0]  rem_in    [DIV_STAGES];
   logic [WHEELS-1:0][QUOT_W-1:0] quot_ff   [DIV_STAGES];
   logic [WHEELS-1:0][QUOT_W-1:0] quot_in   [DIV_STAGES];
   logic [WHEELS-1:0]             neg_ff    [DIV_STAGES];

   // stage inputs: stage 0 from the normalizer, the rest from the previous stage
   logic [DIV_STAGES-1:0]         stg_valid;
   logic [DIV_W-1:0]              stg_div   [DIV_STAGES];
   logic [WHEELS-1:0][NUM_W-1:0]  stg_rem   [DIV_STAGES];
   logic [WHEELS-1:0][QUOT_W-1:0] stg_quot  [DIV_STAGES];
   logic [WHEELS-1:0]             stg_neg   [DIV_STAGES];

   always_comb begin
      stg_valid[0] = in_valid;
      stg_div[0]   = in_norm.divisor;
      stg_rem[0]   = in_norm.num;
      stg_quot[0]  = '0;
      stg_neg[0]   = in_norm.neg;
      for (int s = 1; s < DIV_STAGES; s++) begin
         stg_valid[s] = valid_ff[s-1];
         stg_div[s]   = div_ff[s-1];
         stg_rem[s]   = rem_ff[s-1];
         stg_quot[s]  = quot_ff[s-1];
         stg_neg[s]   = neg_ff[s-1];
      end
   end

   // compare and subtract of the shifted divisor, MSB first
   always_comb begin
      logic [NUM_W-1:0]  rem_v;
      logic [NUM_W-1:0]  trial;
      logic [QUOT_W-1:0] quot_v;
      int                bit_idx;
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int w = 0; w < WHEELS; w++) begin
            rem_v  = stg_rem[s][w];
            quot_v = stg_quot[s][w];
            for (int j = 0; j < STEP_BITS; j++) begin
               bit_idx = QUOT_W - 1 - s * STEP_BITS - j;
               if (bit_idx >= 0) begin
                  trial = NUM_W'(stg_div[s]) << bit_idx;
                  if (rem_v >= trial) begin
                     rem_v          = rem_v - trial;
                     quot_v[bit_idx] = 1'b1;
                  end
               end
            end
            rem_in[s][w]  = rem_v;
            quot_in[s][w] = quot_v;
         end
      end
   end

   // per-stage flow control: a stage loads when empty or draining
   always_comb begin
      ready[DIV_STAGES] = out_ready;
      for (int s = DIV_STAGES - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= stg_valid[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (ready[s] && stg_valid[s]) begin
            div_ff[s]  <= stg_div[s];
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
            neg_ff[s]  <= stg_neg[s];
         end
      end
   end

   assign in_ready      = ready[0];
   assign out_valid     = valid_ff[DIV_STAGES-1];
   assign out_quot.quot = quot_ff[DIV_STAGES-1];
   assign out_quot.neg  = neg_ff[DIV_STAGES-1];

endmodule

>>> src/mecanum_joystick_wheel_mixer.sv
// Top level of the mecanum joystick wheel mixer: register port, pipeline and result register.
//
// Takes one joystick sample per transaction and returns the eight wheel duty percents
// (forward and reverse for each wheel) for every sample whose moved flag is set; samples
// with moved clear are accepted and dropped. The block accepts one sample every clock
// cycle unless backpressure stalls it; each result passes through mixing, normalization,
// four divider stages (two quotient bits each, all four wheels in parallel) and the result
// register. Every stage holds its transaction while the next one is full, so backpressure
// on the result side stalls only as far back as the pipeline is occupied.
// Registers: 0x0 axis_full_scale (8 bits), 0x4 dead_zone (7 bits), 0x8 full_turn (1 bit).
// Write them only while no sample is in flight.
module mecanum_joystick_wheel_mixer import mjwm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   mjwm_req_if.sink          req_chan,
   mjwm_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type     cfg_ff;
   reg_idx_type reg_idx;
   logic        csr_write;

   axes_type    req_axes;
   logic        mix_in_valid, mix_ready, mix_valid;
   sum_vec_type mix_sums;
   logic        norm_ready, norm_valid;
   norm_type    norm_data;
   logic        div_ready, div_valid;
   quot_type    div_quot;

   logic                          out_valid_ff, out_ready;
   logic [WHEELS-1:0][QUOT_W-1:0] fwd_ff, fwd_in, rev_ff, rev_in;

   // ---- register port ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_idx_type'(csr_paddr[ADDR_W-1 -: REG_IDX_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale <= RST_FULL_SCALE;
         cfg_ff.dead_zone  <= RST_DEAD_ZONE;
         cfg_ff.full_turn  <= RST_FULL_TURN;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_FULL_SCALE: cfg_ff.full_scale <= csr_pwdata[FS_W-1:0];
            REG_DEAD_ZONE:  cfg_ff.dead_zone  <= csr_pwdata[DZ_W-1:0];
            REG_FULL_TURN:  cfg_ff.full_turn  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FULL_SCALE: csr_prdata = DATA_W'(cfg_ff.full_scale);
         REG_DEAD_ZONE:  csr_prdata = DATA_W'(cfg_ff.dead_zone);
         REG_FULL_TURN:  csr_prdata = DATA_W'(cfg_ff.full_turn);
         default:        csr_prdata = '0;
      endcase
   end

   // ---- pipeline ----
   assign req_axes.left_x  = req_chan.left_x;
   assign req_axes.left_y  = req_chan.left_y;
   assign req_axes.right_x = req_chan.right_x;
   assign req_axes.right_y = req_chan.right_y;

   // samples without movement are taken but never enter the pipeline
   assign mix_in_valid   = req_chan.valid && req_chan.moved;
   assign req_chan.ready = mix_ready;

   mjwm_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_in_valid),
      .in_ready  (mix_ready),
      .in_axes   (req_axes),
      .cfg       (cfg_ff),
      .out_valid (mix_valid),
      .out_ready (norm_ready),
      .out_sums  (mix_sums)
   );

   mjwm_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (norm_ready),
      .in_sums   (mix_sums),
      .cfg       (cfg_ff),
      .out_valid (norm_valid),
      .out_ready (div_ready),
      .out_norm  (norm_data)
   );

   mjwm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (div_ready),
      .in_norm   (norm_data),
      .out_valid (div_valid),
      .out_ready (out_ready),
      .out_quot  (div_quot)
   );

   // ---- result register: split each signed percent into forward and reverse ----
   always_comb begin
      for (int w = 0; w < WHEELS; w++) begin
         fwd_in[w] = div_quot.neg[w] ? '0 : div_quot.quot[w];
         rev_in[w] = div_quot.neg[w] ? div_quot.quot[w] : '0;
      end
   end

   assign out_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_valid) begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.front_left_fwd  = fwd_ff[WHL_FL];
   assign rsp_chan.front_left_rev  = rev_ff[WHL_FL];
   assign rsp_chan.front_right_fwd = fwd_ff[WHL_FR];
   assign rsp_chan.front_right_rev = rev_ff[WHL_FR];
   assign rsp_chan.back_left_fwd   = fwd_ff[WHL_BL];
   assign rsp_chan.back_left_rev   = rev_ff[WHL_BL];
   assign rsp_chan.back_right_fwd  = fwd_ff[WHL_BR];
   assign rsp_chan.back_right_rev  = rev_ff[WHL_BR];

   // ---- assertions ----
   // a sample without movement never occupies the mixing stage
   a_drop_unmoved: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.moved) |=> !mix_valid)
      else $error("unmoved sample entered the pipeline");

   // a moved sample always lands in the mixing stage
   a_take_moved: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.moved) |=> mix_valid)
      else $error("moved sample lost at pipeline entry");

   // no wheel is driven forward and reverse at once
   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((fwd_ff[WHL_FL] == '0 || rev_ff[WHL_FL] == '0)
                       && (fwd_ff[WHL_FR] == '0 || rev_ff[WHL_FR] == '0)
                       && (fwd_ff[WHL_BL] == '0 || rev_ff[WHL_BL] == '0)
                       && (fwd_ff[WHL_BR] == '0 || rev_ff[WHL_BR] == '0)))
      else $error("wheel driven in both directions");

   // the divisor never falls below a wheel magnitude, so duties stay within 100
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> (div_quot.quot[WHL_FL] <= QUOT_W'(PERCENT)
                  && div_quot.quot[WHL_FR] <= QUOT_W'(PERCENT)
                  && div_quot.quot[WHL_BL] <= QUOT_W'(PERCENT)
                  && div_quot.quot[WHL_BR] <= QUOT_W'(PERCENT)))
      else $error("duty percent above full scale");

endmodule

>>> bench/mecanum_joystick_wheel_mixer_tb.sv
// Testbench for the mecanum wheel mixer: directed and random joystick samples, scoreboard check.
module mecanum_joystick_wheel_mixer_tb;
   import mjwm_pkg::*;

   localparam int BAD_REG_IDX   = 3;    // no register behind this index
   localparam int DRAIN_CYCLES  = 20;   // pipeline is 7 deep, leave margin
   localparam int PHASE_SAMPLES = 150;  // moved samples per register setting
   localparam int DUTY_FIELDS   = 2 * WHEELS;

   // index 2*wheel is the forward duty, 2*wheel+1 the reverse duty
   typedef logic [DUTY_FIELDS-1:0][QUOT_W-1:0] duty_vec_type;

   // Scoreboard: register shadow, wheel duty predictor and queue of expected duties
   class duty_scoreboard;
      logic [FS_W-1:0] full_scale = RST_FULL_SCALE;
      logic [DZ_W-1:0] dead_zone  = RST_DEAD_ZONE;
      logic            full_turn  = RST_FULL_TURN;
      duty_vec_type    expected_duties[$];
      int              errors;
      int              samples_seen;
      int              results_seen;
      string           field_name[DUTY_FIELDS] = '{
         "front_left_fwd", "front_left_rev", "front_right_fwd", "front_right_rev",
         "back_left_fwd", "back_left_rev", "back_right_fwd", "back_right_rev"};

      function int iabs(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void set_reg(int idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_FULL_SCALE: full_scale = value[FS_W-1:0];
            REG_DEAD_ZONE:  dead_zone  = value[DZ_W-1:0];
            REG_FULL_TURN:  full_turn  = value[0];
            default: ;  // unmapped index, write dropped
         endcase
      endfunction

      function logic [DATA_W-1:0] reg_value(int idx);
         case (idx)
            REG_FULL_SCALE: return DATA_W'(full_scale);
            REG_DEAD_ZONE:  return DATA_W'(dead_zone);
            default:        return DATA_W'(full_turn);
         endcase
      endfunction

      // Mix the axes into four wheel speeds and split them into duty percents
      function duty_vec_type mix_wheels(axes_type a);
         int           y, x, r, k, dz, fs, peak, divisor, pct;
         int           speed[WHEELS];
         duty_vec_type res;
         dz = dead_zone;
         fs = (full_scale == 0) ? 1 : full_scale;
         k  = full_turn ? 2 : 1;
         // forward falls back to the right stick, without dead zone
         y  = (iabs(a.left_y) > dz) ? -int'(a.left_y) : -int'(a.right_y);
         x  = (iabs(a.left_x) > dz) ? int'(a.left_x) : 0;
         r  = (iabs(a.right_x) > dz) ? int'(a.right_x) : 0;
         speed[WHL_FL] = y + x + k * r;
         speed[WHL_FR] = y - x - k * r;
         speed[WHL_BL] = y - x + k * r;
         speed[WHL_BR] = y + x - k * r;
         peak = 0;
         foreach (speed[i]) if (iabs(speed[i]) > peak) peak = iabs(speed[i]);
         divisor = (peak > fs) ? peak : fs;
         foreach (speed[i]) begin
            pct = iabs(speed[i] * PERCENT) / divisor;   // truncate toward zero
            res[2*i]     = (speed[i] > 0) ? QUOT_W'(pct) : '0;
            res[2*i + 1] = (speed[i] < 0) ? QUOT_W'(pct) : '0;
         end
         return res;
      endfunction

      function void note_sample(axes_type a, logic moved);
         samples_seen++;
         if (moved) expected_duties.push_back(mix_wheels(a));
      endfunction

      function void check_duties(duty_vec_type got);
         duty_vec_type want;
         results_seen++;
         if (expected_duties.size() == 0) begin
            errors++;
            $display("%0t: unexpected duty result %h, none pending", $time, got);
            return;
         end
         want = expected_duties.pop_front();
         for (int i = 0; i < DUTY_FIELDS; i++) begin
            if (got[i] !== want[i]) begin
               errors++;
               $display("%0t: %s expected %0d, got %0d", $time, field_name[i],
                        want[i], got[i]);
            end
         end
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [DATA_W-1:0] csr_pwdata  = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;
   bit                quiet       = 1'b0;   // no idling on either side
   int                gap_odds;

   duty_scoreboard duties = new();

   mjwm_req_if req_chan();
   mjwm_rsp_if rsp_chan();

   mecanum_joystick_wheel_mixer uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Result side: ready runs and stall bursts, driven at the falling edge
   initial begin : rsp_ready_gen
      int run;
      rsp_chan.ready = 1'b0;
      run = 0;
      forever begin
         @(negedge clock);
         if (run == 0) begin
            if (quiet || $urandom_range(0, 2) != 0) begin
               rsp_chan.ready = 1'b1;
               run = $urandom_range(1, 40);
            end else begin
               rsp_chan.ready = 1'b0;
               run = $urandom_range(1, 18);
            end
         end
         run--;
      end
   end

   // Result monitor: every accepted transaction goes to the scoreboard
   always @(posedge clock) begin : rsp_monitor
      duty_vec_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got[2*WHL_FL]     = rsp_chan.front_left_fwd;
         got[2*WHL_FL + 1] = rsp_chan.front_left_rev;
         got[2*WHL_FR]     = rsp_chan.front_right_fwd;
         got[2*WHL_FR + 1] = rsp_chan.front_right_rev;
         got[2*WHL_BL]     = rsp_chan.back_left_fwd;
         got[2*WHL_BL + 1] = rsp_chan.back_left_rev;
         got[2*WHL_BR]     = rsp_chan.back_right_fwd;
         got[2*WHL_BR + 1] = rsp_chan.back_right_rev;
         duties.check_duties(got);
      end
   end

   // One sample transaction; called and returns at a falling edge, valid left high
   task automatic send_sample(int lx, int ly, int rx, int ry, logic moved);
      axes_type a;
      a.left_x  = AXIS_W'(lx);
      a.left_y  = AXIS_W'(ly);
      a.right_x = AXIS_W'(rx);
      a.right_y = AXIS_W'(ry);
      req_chan.left_x  = a.left_x;
      req_chan.left_y  = a.left_y;
      req_chan.right_x = a.right_x;
      req_chan.right_y = a.right_y;
      req_chan.moved   = moved;
      req_chan.valid   = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      duties.note_sample(a, moved);
      @(negedge clock);
   endtask

   // Stop sending and let every expected result and any dropped sample clear the pipe
   task automatic drain();
      req_chan.valid = 1'b0;
      while (duties.expected_duties.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(int idx, logic [DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = ADDR_W'(idx * 4);
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      duties.set_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic read_reg(int idx);
      logic [DATA_W-1:0] got;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = ADDR_W'(idx * 4);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      if (got !== duties.reg_value(idx)) begin
         duties.errors++;
         $display("%0t: register %0d expected %h, got %h", $time, idx,
                  duties.reg_value(idx), got);
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Random axis value, weighted toward the dead zone edge, zero and the extremes
   function automatic int pick_axis(int dz);
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = int'($signed(AXIS_W'($urandom_range(0, 255))));
         4, 5: begin
            v = dz - 1 + $urandom_range(0, 2);
            if (v < 0) v = 0;
            if (v > 128) v = 128;
            if ($urandom_range(0, 1)) v = -v;
            if (v == 128) v = 127;
         end
         6: v = 0;
         7: begin
            case ($urandom_range(0, 2))
               0: v = -128;
               1: v = 127;
               default: v = -127;
            endcase
         end
         default: v = int'($urandom_range(0, 15)) - 8;
      endcase
      return v;
   endfunction

   // New register setting, read back, then random samples
   task automatic run_phase(int fs, int dz, int ft, bit poke_unmapped);
      int moved_sent;
      logic moved;
      drain();
      write_reg(REG_FULL_SCALE, ($urandom & ~DATA_W'(8'hFF)) | DATA_W'(fs));
      write_reg(REG_DEAD_ZONE, ($urandom & ~DATA_W'(7'h7F)) | DATA_W'(dz));
      write_reg(REG_FULL_TURN, ($urandom & ~DATA_W'(1)) | DATA_W'(ft));
      if (poke_unmapped) write_reg(BAD_REG_IDX, $urandom);
      read_reg(REG_FULL_SCALE);
      read_reg(REG_DEAD_ZONE);
      read_reg(REG_FULL_TURN);
      moved_sent = 0;
      while (moved_sent < PHASE_SAMPLES) begin
         if (moved_sent % 64 == 0) gap_odds = $urandom_range(0, 3);
         // halfway through, hold off until the pipe is empty
         if (moved_sent == PHASE_SAMPLES / 2) begin
            req_chan.valid = 1'b0;
            while (duties.expected_duties.size() != 0) @(negedge clock);
         end
         moved = ($urandom_range(0, 7) != 0);
         send_sample(pick_axis(dz), pick_axis(dz), pick_axis(dz), pick_axis(dz), moved);
         if (moved) moved_sent++;
         if (!quiet && gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
            req_chan.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
      end
   endtask

   initial begin : stimulus
      req_chan.valid   = 1'b0;
      req_chan.left_x  = '0;
      req_chan.left_y  = '0;
      req_chan.right_x = '0;
      req_chan.right_y = '0;
      req_chan.moved   = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed samples at the reset setting (full scale 128, dead zone 5, full turn)
      send_sample(0, 0, 0, 0, 1'b1);
      send_sample(-128, -128, -128, -128, 1'b0);   // moved clear: dropped
      send_sample(127, -128, 127, -128, 1'b1);
      send_sample(-128, 127, -128, 127, 1'b1);
      send_sample(-128, -128, -128, -128, 1'b1);
      send_sample(127, 127, 127, 127, 1'b1);
      send_sample(5, 5, 5, -100, 1'b1);             // all inside dead zone, right_y drives
      send_sample(6, -6, -6, 50, 1'b1);             // just outside dead zone
      send_sample(-5, -5, 0, -128, 1'b1);
      send_sample(0, 0, 0, 127, 1'b1);
      send_sample(0, -128, 0, 0, 1'b1);             // pure forward, full deflection
      send_sample(127, 0, 0, 0, 1'b1);              // pure strafe
      send_sample(0, 0, -128, 0, 1'b1);             // pure rotation, normalized
      send_sample(127, -128, 127, 0, 1'b1);         // large sums, normalized
      send_sample(-128, 0, 127, 0, 1'b1);
      send_sample(0, 0, 0, 0, 1'b0);
      send_sample(40, -60, 20, 0, 1'b1);
      send_sample(-1, 1, -1, 1, 1'b1);

      run_phase(1, 127, 0, 1'b0);
      run_phase(255, 0, 1, 1'b0);
      run_phase(0, 64, 1, 1'b0);                    // full scale 0 acts as 1
      run_phase(200, 10, 0, 1'b0);
      run_phase($urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 1), 1'b0);
      quiet = 1'b1;
      run_phase(RST_FULL_SCALE, RST_DEAD_ZONE, RST_FULL_TURN, 1'b1);
      drain();

      $display("Sent %0d joystick samples over 7 register settings, checked %0d duty results.",
               duties.samples_seen, duties.results_seen);
      $display("Included dead zone edges, right stick fallback, normalization and bad register.");
      if (duties.errors == 0 && duties.expected_duties.size() == 0) begin
         $display("mecanum_joystick_wheel_mixer: match");
      end else begin
         $display("mecanum_joystick_wheel_mixer: mismatch");
      end
      $finish;
   end

   // Watchdog on the whole run
   initial begin : run_limit
      #3000000;
      $display("Run timed out with %0d results pending.", duties.expected_duties.size());
      $display("mecanum_joystick_wheel_mixer: mismatch");
      $finish;
   end

endmodule
